>>> src/swsfd_pkg.sv
package swsfd_pkg;

	localparam int TICKS_PER_US = 80;
	localparam int FRAME_BITS   = 40;
	localparam int TICK_W       = 32;
	localparam int CFG_W        = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int BIT_IDX_W    = 6;
	// Threshold in ticks that the elapsed time must reach: (us + 1) * TICKS_PER_US
	localparam int THR_W = $clog2(((1 << CFG_W) * TICKS_PER_US) + 1);

	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_EDGE    = 2'd1,
		REQ_TIMEOUT = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_CHECKSUM = 2'd1,
		STS_TIMEOUT  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_HIGH_MIN = 3'd0,
		CFG_START_END_MIN  = 3'd1,
		CFG_BIT_LOW_MIN    = 3'd2,
		CFG_BIT_HIGH_MIN   = 3'd3,
		CFG_ONE_MIN        = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_START      = 5'b00010,
		PH_START_HIGH = 5'b00100,
		PH_BIT_LOW    = 5'b01000,
		PH_BIT_HIGH   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TICK_W-1:0] time_ticks;
		logic              line_level;
	} item_t;

	typedef struct packed {
		logic [THR_W-1:0] start_high;
		logic [THR_W-1:0] start_end;
		logic [THR_W-1:0] bit_low;
		logic [THR_W-1:0] bit_high;
		logic [THR_W-1:0] one;
	} thr_t;

	function automatic logic [THR_W-1:0] thr_of(input logic [CFG_W-1:0] us);
		logic [THR_W-1:0] t;
		t = (THR_W'(us) + THR_W'(1)) * THR_W'(TICKS_PER_US);
		return t;
	endfunction

endpackage

>>> src/swsfd_cfg.sv
module swsfd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swsfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swsfd_pkg::CFG_W-1:0]         cfg_data,
	output swsfd_pkg::thr_t                     thr
);

	swsfd_pkg::thr_t                 thr_q;
	logic [swsfd_pkg::THR_W-1:0]     thr_new;

	// Store thresholds in ticks so the datapath needs no divide
	assign thr_new = swsfd_pkg::thr_of(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.start_high <= swsfd_pkg::thr_of(swsfd_pkg::CFG_W'(80));
			thr_q.start_end  <= swsfd_pkg::thr_of(swsfd_pkg::CFG_W'(160));
			thr_q.bit_low    <= swsfd_pkg::thr_of(swsfd_pkg::CFG_W'(30));
			thr_q.bit_high   <= swsfd_pkg::thr_of(swsfd_pkg::CFG_W'(10));
			thr_q.one        <= swsfd_pkg::thr_of(swsfd_pkg::CFG_W'(50));
		end else if (cfg_we) begin
			case (cfg_index)
				swsfd_pkg::CFG_START_HIGH_MIN: thr_q.start_high <= thr_new;
				swsfd_pkg::CFG_START_END_MIN:  thr_q.start_end  <= thr_new;
				swsfd_pkg::CFG_BIT_LOW_MIN:    thr_q.bit_low    <= thr_new;
				swsfd_pkg::CFG_BIT_HIGH_MIN:   thr_q.bit_high   <= thr_new;
				swsfd_pkg::CFG_ONE_MIN:        thr_q.one        <= thr_new;
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

>>> src/swsfd_in_stage.sv
module swsfd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swsfd_pkg::item_t  in_item,
	output logic              valid_s1,
	output swsfd_pkg::item_t  item_s1,
	input  logic              take
);

	logic             vld_s1;
	swsfd_pkg::item_t itm_s1;

	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_s1 <= in_item;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;

endmodule

>>> src/swsfd_core.sv
module swsfd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swsfd_pkg::thr_t            thr,
	input  logic                       valid_s1,
	input  swsfd_pkg::item_t           item_s1,
	output logic                       take,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [7:0]                 humidity_whole,
	output logic [7:0]                 humidity_fraction,
	output logic [7:0]                 temperature_whole,
	output logic [7:0]                 temperature_fraction
);

	localparam int FB = swsfd_pkg::FRAME_BITS;
	localparam int TW = swsfd_pkg::TICK_W;

	swsfd_pkg::phase_t                   phase_q, phase_n;
	logic [TW-1:0]                       mark_q, mark_n;
	logic [swsfd_pkg::BIT_IDX_W-1:0]     bit_idx_q, bit_idx_n, bit_idx_inc;
	logic [FB-1:0]                       frame_q, frame_n, frame_sh;
	logic [TW-1:0]                       ticks;
	logic                                pass_sh, pass_se, pass_bl, pass_bh, is_one;
	logic                                res_vld;
	logic [1:0]                          res_sts;
	logic [FB-1:0]                       res_frame;
	logic [7:0]                          sum;
	logic                                out_free;
	logic                                out_vld_q;
	logic [1:0]                          sts_q;
	logic [31:0]                         bytes_q;
	logic                                load;

	// Elapsed ticks, wrapping; "us > min" is the same as "ticks >= (min + 1) * TICKS_PER_US"
	assign ticks   = item_s1.time_ticks - mark_q;
	assign pass_sh = ticks >= TW'(thr.start_high);
	assign pass_se = ticks >= TW'(thr.start_end);
	assign pass_bl = ticks >= TW'(thr.bit_low);
	assign pass_bh = ticks >= TW'(thr.bit_high);
	assign is_one  = ticks >= TW'(thr.one);

	assign frame_sh    = {frame_q[FB-2:0], is_one};
	assign bit_idx_inc = bit_idx_q + 1'b1;
	assign sum = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];

	always_comb begin
		phase_n   = phase_q;
		mark_n    = mark_q;
		bit_idx_n = bit_idx_q;
		frame_n   = frame_q;
		res_vld   = 1'b0;
		res_sts   = swsfd_pkg::STS_OK;
		res_frame = frame_sh;
		if (item_s1.req_type == swsfd_pkg::REQ_START) begin
			phase_n = swsfd_pkg::PH_START;
			mark_n  = item_s1.time_ticks;
		end else if (item_s1.req_type == swsfd_pkg::REQ_TIMEOUT) begin
			case (phase_q)
				swsfd_pkg::PH_START, swsfd_pkg::PH_START_HIGH,
				swsfd_pkg::PH_BIT_LOW, swsfd_pkg::PH_BIT_HIGH: begin
					phase_n   = swsfd_pkg::PH_IDLE;
					res_vld   = 1'b1;
					res_sts   = swsfd_pkg::STS_TIMEOUT;
					res_frame = '0;
				end
				default: ;
			endcase
		end else if (item_s1.req_type == swsfd_pkg::REQ_EDGE) begin
			case (phase_q)
				swsfd_pkg::PH_START: begin
					if (item_s1.line_level && pass_sh) begin
						phase_n = swsfd_pkg::PH_START_HIGH;
					end
				end
				swsfd_pkg::PH_START_HIGH: begin
					if (!item_s1.line_level && pass_se) begin
						phase_n   = swsfd_pkg::PH_BIT_LOW;
						mark_n    = item_s1.time_ticks;
						bit_idx_n = '0;
						frame_n   = '0;
					end
				end
				swsfd_pkg::PH_BIT_LOW: begin
					if (item_s1.line_level && pass_bl) begin
						phase_n = swsfd_pkg::PH_BIT_HIGH;
						mark_n  = item_s1.time_ticks;
					end
				end
				swsfd_pkg::PH_BIT_HIGH: begin
					if (!item_s1.line_level && pass_bh) begin
						phase_n   = swsfd_pkg::PH_BIT_LOW;
						mark_n    = item_s1.time_ticks;
						frame_n   = frame_sh;
						bit_idx_n = bit_idx_inc;
						if (bit_idx_inc >= swsfd_pkg::BIT_IDX_W'(FB)) begin
							phase_n = swsfd_pkg::PH_IDLE;
							res_vld = 1'b1;
							res_sts = (sum == frame_sh[7:0]) ? swsfd_pkg::STS_OK
							                                 : swsfd_pkg::STS_CHECKSUM;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Advance an item unless it has a result and the output slot is still full
	assign out_free = !out_vld_q || out_ready;
	assign take     = valid_s1 && (!res_vld || out_free);
	assign load     = take && res_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= swsfd_pkg::PH_IDLE;
			mark_q    <= '0;
			bit_idx_q <= '0;
			frame_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q   <= phase_n;
				mark_q    <= mark_n;
				bit_idx_q <= bit_idx_n;
				frame_q   <= frame_n;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sts_q   <= res_sts;
			bytes_q <= res_frame[FB-1:8];
		end
	end

	assign out_valid            = out_vld_q;
	assign status               = sts_q;
	assign humidity_whole       = bytes_q[31:24];
	assign humidity_fraction    = bytes_q[23:16];
	assign temperature_whole    = bytes_q[15:8];
	assign temperature_fraction = bytes_q[7:0];

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (sts_q == swsfd_pkg::STS_TIMEOUT) |-> (bytes_q == '0))
		else $error("timeout result carries data bytes");

	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (phase_q == swsfd_pkg::PH_IDLE))
		else $error("decoder not idle after a result");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swsfd_pkg::PH_BIT_LOW || phase_q == swsfd_pkg::PH_BIT_HIGH)
		|-> (bit_idx_q < swsfd_pkg::BIT_IDX_W'(FB)))
		else $error("bit index past frame length while receiving");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_vld_q || out_ready))
		else $error("result register overwritten while held");

endmodule

>>> src/single_wire_sensor_frame_decoder.sv
// Channel  Signals                                           Transfer
// in       in_valid/in_ready: req_type time_ticks line_level  valid & ready at clk rise
// out      out_valid/out_ready: status humidity_* temp_*       valid & ready at clk rise
// cfg      cfg_we cfg_index cfg_data                           cfg_we at clk rise
//
// One transaction per cycle while no result stalls: each one is registered in the input
// register, then one pass of compare and shift logic updates the decoder state and loads
// the result register, whose contents drive the out channel and out_valid.
// Transactions with no result keep flowing while a result waits; one with a result stalls
// in the input register until the result register is free.
// arst_n clears control state, phase to idle and thresholds to their defaults.
module single_wire_sensor_frame_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [swsfd_pkg::TICK_W-1:0]     time_ticks,
	input  logic                             line_level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [7:0]                       humidity_whole,
	output logic [7:0]                       humidity_fraction,
	output logic [7:0]                       temperature_whole,
	output logic [7:0]                       temperature_fraction,
	input  logic                             cfg_we,
	input  logic [swsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsfd_pkg::CFG_W-1:0]      cfg_data
);

	swsfd_pkg::thr_t  thr;
	swsfd_pkg::item_t in_item;
	swsfd_pkg::item_t item_s1;
	logic             valid_s1;
	logic             take;

	assign in_item.req_type   = req_type;
	assign in_item.time_ticks = time_ticks;
	assign in_item.line_level = line_level;

	swsfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	swsfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	swsfd_core u_core (
		.clk                  (clk),
		.arst_n               (arst_n),
		.thr                  (thr),
		.valid_s1             (valid_s1),
		.item_s1              (item_s1),
		.take                 (take),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.status               (status),
		.humidity_whole       (humidity_whole),
		.humidity_fraction    (humidity_fraction),
		.temperature_whole    (temperature_whole),
		.temperature_fraction (temperature_fraction)
	);

endmodule

>>> tb/sv/tb_single_wire_sensor_frame_decoder.sv
module tb_single_wire_sensor_frame_decoder;

	localparam int NUM_REGS = int'(swsfd_pkg::CFG_ONE_MIN) + 1;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		swsfd_pkg::status_t status;
		logic [7:0] hum_whole;
		logic [7:0] hum_frac;
		logic [7:0] temp_whole;
		logic [7:0] temp_frac;
	} sensor_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [swsfd_pkg::TICK_W-1:0] time_ticks = '0;
	logic line_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] humidity_whole;
	logic [7:0] humidity_fraction;
	logic [7:0] temperature_whole;
	logic [7:0] temperature_fraction;
	logic cfg_we = 1'b0;
	logic [swsfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [swsfd_pkg::CFG_W-1:0] cfg_data = '0;

	// stimulus side
	swsfd_pkg::item_t line_events[$];
	swsfd_pkg::item_t on_wire;
	bit offering = 1'b0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	int items_offered = 0;
	int items_taken = 0;
	int reply_left;
	bit reply_cut;
	int settings_loaded = 0;

	// decoder shadow state
	logic [swsfd_pkg::CFG_W-1:0] cfg_now [NUM_REGS];
	swsfd_pkg::phase_t line_phase = swsfd_pkg::PH_IDLE;
	logic [swsfd_pkg::TICK_W-1:0] line_mark = '0;
	int bits_in = 0;
	logic [swsfd_pkg::FRAME_BITS-1:0] frame_acc = '0;
	sensor_reading_t readings_due[$];
	int n_clean = 0;
	int n_bad_sum = 0;
	int n_timeout = 0;

	// result side
	sensor_reading_t want;
	int stall_left = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int errors = 0;
	int cycles = 0;

	single_wire_sensor_frame_decoder DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.req_type             (req_type),
		.time_ticks           (time_ticks),
		.line_level           (line_level),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.status               (status),
		.humidity_whole       (humidity_whole),
		.humidity_fraction    (humidity_fraction),
		.temperature_whole    (temperature_whole),
		.temperature_fraction (temperature_fraction),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_idle();
		return idle_on ? int'($urandom_range(0, 19)) : 0;
	endfunction

	function automatic logic [swsfd_pkg::TICK_W-1:0] min_ticks(
			input logic [swsfd_pkg::CFG_W-1:0] us);
		return (swsfd_pkg::TICK_W'(us) + swsfd_pkg::TICK_W'(1))
			* swsfd_pkg::TICK_W'(swsfd_pkg::TICKS_PER_US);
	endfunction

	function automatic logic [swsfd_pkg::TICK_W-1:0] past_ticks(
			input logic [swsfd_pkg::CFG_W-1:0] us);
		if ($urandom_range(0, 7) == 0)
			return min_ticks(us);
		return min_ticks(us)
			+ swsfd_pkg::TICK_W'($urandom_range(0, 4 * swsfd_pkg::TICKS_PER_US));
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic void post_reading(input swsfd_pkg::status_t st,
			input logic [swsfd_pkg::FRAME_BITS-1:0] frame);
		sensor_reading_t r;
		r.status = st;
		r.hum_whole = frame[39:32];
		r.hum_frac = frame[31:24];
		r.temp_whole = frame[23:16];
		r.temp_frac = frame[15:8];
		readings_due.push_back(r);
		case (st)
		swsfd_pkg::STS_OK: n_clean++;
		swsfd_pkg::STS_CHECKSUM: n_bad_sum++;
		default: n_timeout++;
		endcase
	endfunction

	// Advance the shadow decoder by one accepted transaction.
	task automatic track_sensor_line(input swsfd_pkg::item_t it);
		logic [swsfd_pkg::TICK_W-1:0] dt_us;
		logic [7:0] sum8;
		dt_us = (it.time_ticks - line_mark) / swsfd_pkg::TICK_W'(swsfd_pkg::TICKS_PER_US);
		case (it.req_type)
		swsfd_pkg::REQ_START: begin
			line_phase = swsfd_pkg::PH_START;
			line_mark = it.time_ticks;
		end
		swsfd_pkg::REQ_TIMEOUT: begin
			if (line_phase != swsfd_pkg::PH_IDLE) begin
				line_phase = swsfd_pkg::PH_IDLE;
				post_reading(swsfd_pkg::STS_TIMEOUT, '0);
			end
		end
		swsfd_pkg::REQ_EDGE: begin
			case (line_phase)
			swsfd_pkg::PH_START: begin
				if (it.line_level && dt_us > cfg_now[swsfd_pkg::CFG_START_HIGH_MIN])
					line_phase = swsfd_pkg::PH_START_HIGH;
			end
			swsfd_pkg::PH_START_HIGH: begin
				if (!it.line_level && dt_us > cfg_now[swsfd_pkg::CFG_START_END_MIN]) begin
					line_phase = swsfd_pkg::PH_BIT_LOW;
					line_mark = it.time_ticks;
					bits_in = 0;
					frame_acc = '0;
				end
			end
			swsfd_pkg::PH_BIT_LOW: begin
				if (it.line_level && dt_us > cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN]) begin
					line_phase = swsfd_pkg::PH_BIT_HIGH;
					line_mark = it.time_ticks;
				end
			end
			swsfd_pkg::PH_BIT_HIGH: begin
				if (!it.line_level && dt_us > cfg_now[swsfd_pkg::CFG_BIT_HIGH_MIN]) begin
					frame_acc = {frame_acc[swsfd_pkg::FRAME_BITS-2:0],
						dt_us > cfg_now[swsfd_pkg::CFG_ONE_MIN]};
					line_phase = swsfd_pkg::PH_BIT_LOW;
					line_mark = it.time_ticks;
					bits_in++;
					if (bits_in >= swsfd_pkg::FRAME_BITS) begin
						sum8 = frame_acc[39:32] + frame_acc[31:24] + frame_acc[23:16]
							+ frame_acc[15:8];
						line_phase = swsfd_pkg::PH_IDLE;
						post_reading((sum8 == frame_acc[7:0]) ? swsfd_pkg::STS_OK
							: swsfd_pkg::STS_CHECKSUM, frame_acc);
					end
				end
			end
			default: ;
			endcase
		end
		default: ;
		endcase
	endtask

	task automatic offer(input logic [1:0] req, input logic [swsfd_pkg::TICK_W-1:0] t,
			input logic lvl);
		swsfd_pkg::item_t it;
		it.req_type = req;
		it.time_ticks = t;
		it.line_level = lvl;
		line_events.push_back(it);
		items_offered++;
	endtask

	// Drop everything once the reply has been cut; a counted edge may end it with a timeout.
	task automatic reply_event(input logic [swsfd_pkg::TICK_W-1:0] t, input logic lvl,
			input bit counted);
		if (reply_cut)
			return;
		offer(swsfd_pkg::REQ_EDGE, t, lvl);
		if (counted) begin
			reply_left--;
			if (reply_left == 0) begin
				offer(swsfd_pkg::REQ_TIMEOUT, $urandom, 1'($urandom));
				reply_cut = 1'b1;
			end
		end
	endtask

	// Now and then slip in an edge one tick short of the threshold or of the wrong level.
	task automatic maybe_glitch(input logic [swsfd_pkg::TICK_W-1:0] mark,
			input logic [swsfd_pkg::CFG_W-1:0] us, input logic lvl);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			reply_event(mark + min_ticks(us) - swsfd_pkg::TICK_W'(1), lvl, 1'b0);
		else if (r == 1)
			reply_event(mark + swsfd_pkg::TICK_W'($urandom_range(0, 2 * min_ticks(us))),
				~lvl, 1'b0);
	endtask

	task automatic send_reply(input int edge_limit);
		logic [7:0] data [4];
		logic [swsfd_pkg::FRAME_BITS-1:0] frame;
		logic [swsfd_pkg::TICK_W-1:0] t0;
		logic [swsfd_pkg::TICK_W-1:0] t;
		int bh;
		int one;
		int hi_us;
		for (int k = 0; k < 4; k++)
			data[k] = pick_byte();
		frame[39:8] = {data[0], data[1], data[2], data[3]};
		frame[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
			: data[0] + data[1] + data[2] + data[3];
		bh = int'(cfg_now[swsfd_pkg::CFG_BIT_HIGH_MIN]);
		one = int'(cfg_now[swsfd_pkg::CFG_ONE_MIN]);
		reply_left = edge_limit;
		reply_cut = 1'b0;
		t0 = ($urandom_range(0, 7) == 0)
			? 32'hFFFF_FFFF - swsfd_pkg::TICK_W'($urandom_range(0, 30000))
			: swsfd_pkg::TICK_W'($urandom);
		offer(swsfd_pkg::REQ_START, t0, 1'($urandom));
		if (reply_left == 0) begin
			offer(swsfd_pkg::REQ_TIMEOUT, $urandom, 1'($urandom));
			reply_cut = 1'b1;
		end
		maybe_glitch(t0, cfg_now[swsfd_pkg::CFG_START_HIGH_MIN], 1'b1);
		t = t0 + past_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]);
		reply_event(t, 1'b1, 1'b1);
		maybe_glitch(t0, cfg_now[swsfd_pkg::CFG_START_END_MIN], 1'b0);
		t = t + swsfd_pkg::TICK_W'($urandom_range(1, 2 * swsfd_pkg::TICKS_PER_US));
		if (t - t0 < min_ticks(cfg_now[swsfd_pkg::CFG_START_END_MIN]))
			t = t0 + past_ticks(cfg_now[swsfd_pkg::CFG_START_END_MIN]);
		reply_event(t, 1'b0, 1'b1);
		for (int k = swsfd_pkg::FRAME_BITS - 1; k >= 0; k--) begin
			maybe_glitch(t, cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN], 1'b1);
			t = t + past_ticks(cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN]);
			reply_event(t, 1'b1, 1'b1);
			if (frame[k])
				hi_us = ((bh > one) ? bh : one) + 1 + int'($urandom_range(0, 40));
			else if (one > bh)
				hi_us = int'($urandom_range(bh + 1, one));
			else
				hi_us = bh + 1;
			maybe_glitch(t, cfg_now[swsfd_pkg::CFG_BIT_HIGH_MIN], 1'b0);
			t = t + swsfd_pkg::TICK_W'(hi_us * swsfd_pkg::TICKS_PER_US
				+ int'($urandom_range(0, swsfd_pkg::TICKS_PER_US - 1)));
			reply_event(t, 1'b0, 1'b1);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			offer(2'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic run_traffic(input int item_goal, input int reading_goal);
		int first;
		int readings;
		int pick;
		first = items_offered;
		readings = 0;
		while (items_offered - first < item_goal || readings < reading_goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				send_reply(-1);
				readings++;
			end else if (pick < 6) begin
				send_reply($urandom_range(0, 2 * swsfd_pkg::FRAME_BITS + 1));
				readings++;
			end else if (pick < 8) begin
				offer(swsfd_pkg::REQ_START, $urandom, 1'($urandom));
				offer(swsfd_pkg::REQ_TIMEOUT, $urandom, 1'($urandom));
				readings++;
			end else begin
				send_noise();
			end
		end
	endtask

	task automatic load_thresholds(input logic [swsfd_pkg::CFG_W-1:0] sh, se, bl, bh, one);
		logic [swsfd_pkg::CFG_W-1:0] vals [NUM_REGS];
		vals[swsfd_pkg::CFG_START_HIGH_MIN] = sh;
		vals[swsfd_pkg::CFG_START_END_MIN] = se;
		vals[swsfd_pkg::CFG_BIT_LOW_MIN] = bl;
		vals[swsfd_pkg::CFG_BIT_HIGH_MIN] = bh;
		vals[swsfd_pkg::CFG_ONE_MIN] = one;
		// unused indexes go last so a stray write would clobber a live value
		for (int k = 0; k < 2 ** swsfd_pkg::CFG_IDX_W; k++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= swsfd_pkg::CFG_IDX_W'(k);
			cfg_data <= (k < NUM_REGS) ? vals[k] : swsfd_pkg::CFG_W'($urandom);
			if (k < NUM_REGS)
				cfg_now[k] = vals[k];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic settle();
		while (line_events.size() != 0 || offering || readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_sensor_line(on_wire);
				items_taken++;
				offering = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (line_events.size() != 0) begin
					on_wire = line_events.pop_front();
					req_type <= on_wire.req_type;
					time_ticks <= on_wire.time_ticks;
					line_level <= on_wire.line_level;
					in_valid <= 1'b1;
					offering = 1'b1;
					gap_left = draw_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string label, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected reading, expected none, actual status %0d bytes %h %h %h %h",
						$time, status, humidity_whole, humidity_fraction,
						temperature_whole, temperature_fraction);
					errors++;
				end else begin
					want = readings_due.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("humidity_whole", want.hum_whole, humidity_whole);
					check_field("humidity_fraction", want.hum_frac, humidity_fraction);
					check_field("temperature_whole", want.temp_whole, temperature_whole);
					check_field("temperature_fraction", want.temp_frac, temperature_fraction);
				end
				stall_left = draw_idle();
			end
			if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: no progress, run stopped after %0d cycles", $time, cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [swsfd_pkg::TICK_W-1:0] t;
		cfg_now[swsfd_pkg::CFG_START_HIGH_MIN] = 10'd80;
		cfg_now[swsfd_pkg::CFG_START_END_MIN] = 10'd160;
		cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN] = 10'd30;
		cfg_now[swsfd_pkg::CFG_BIT_HIGH_MIN] = 10'd10;
		cfg_now[swsfd_pkg::CFG_ONE_MIN] = 10'd50;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle drops, stamps equal and wrapping, re-arm and timeouts at reset thresholds
		t = 32'hFFFF_F000;
		offer(swsfd_pkg::REQ_EDGE, 32'h0, 1'b1);
		offer(swsfd_pkg::REQ_TIMEOUT, 32'hFFFF_FFFF, 1'b0);
		offer(REQ_UNUSED, 32'h0, 1'b1);
		offer(swsfd_pkg::REQ_START, t, 1'b0);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b1);
		offer(swsfd_pkg::REQ_EDGE, t + min_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]), 1'b0);
		offer(swsfd_pkg::REQ_EDGE,
			t + min_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]) - 32'd1, 1'b1);
		offer(swsfd_pkg::REQ_EDGE, t + min_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]), 1'b1);
		offer(swsfd_pkg::REQ_START,
			t + min_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]) + 32'd100, 1'b1);
		offer(swsfd_pkg::REQ_TIMEOUT, 32'h0, 1'b1);
		offer(swsfd_pkg::REQ_TIMEOUT, 32'h0, 1'b1);
		t = 32'h0;
		offer(swsfd_pkg::REQ_START, t, 1'b1);
		offer(swsfd_pkg::REQ_EDGE, t + min_ticks(cfg_now[swsfd_pkg::CFG_START_HIGH_MIN]), 1'b1);
		offer(swsfd_pkg::REQ_EDGE,
			t + min_ticks(cfg_now[swsfd_pkg::CFG_START_END_MIN]) - 32'd1, 1'b0);
		t = t + min_ticks(cfg_now[swsfd_pkg::CFG_START_END_MIN]);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b0);
		t = t + min_ticks(cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN]);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b1);
		t = t + min_ticks(cfg_now[swsfd_pkg::CFG_BIT_HIGH_MIN]);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b0);
		t = t + min_ticks(cfg_now[swsfd_pkg::CFG_BIT_LOW_MIN]);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b1);
		t = t + min_ticks(cfg_now[swsfd_pkg::CFG_ONE_MIN]);
		offer(swsfd_pkg::REQ_EDGE, t, 1'b0);
		offer(swsfd_pkg::REQ_TIMEOUT, 32'hFFFF_FFFF, 1'b0);
		run_traffic(80, 1);
		settle();

		idle_on = 1'b1;
		load_thresholds('0, '0, '0, '0, '0);
		run_traffic(50, 1);
		settle();

		idle_on = 1'b0;
		load_thresholds('1, '1, '1, '1, '1);
		run_traffic(50, 1);
		settle();

		// hold the result side long enough for the input to back up
		holds_asked++;
		repeat (30) begin
			offer(swsfd_pkg::REQ_START, $urandom, 1'($urandom));
			offer(swsfd_pkg::REQ_TIMEOUT, $urandom, 1'($urandom));
		end
		settle();

		repeat (3) begin
			idle_on = 1'($urandom);
			load_thresholds(swsfd_pkg::CFG_W'($urandom), swsfd_pkg::CFG_W'($urandom),
				swsfd_pkg::CFG_W'($urandom), swsfd_pkg::CFG_W'($urandom),
				swsfd_pkg::CFG_W'($urandom));
			run_traffic(70, 1);
			settle();
		end

		idle_on = 1'b1;
		load_thresholds(10'd80, 10'd160, 10'd30, 10'd10, 10'd50);
		run_traffic(50, 1);
		settle();

		$display("Decoded %0d line events over %0d threshold settings (reset values first).",
			items_taken, settings_loaded + 1);
		$display("Readings: %0d clean, %0d bad checksum, %0d timed out; %0d mismatches.",
			n_clean, n_bad_sum, n_timeout, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
src/swsfd_pkg.sv
src/swsfd_cfg.sv
src/swsfd_in_stage.sv
src/swsfd_core.sv
src/single_wire_sensor_frame_decoder.sv
tb/sv/tb_single_wire_sensor_frame_decoder.sv
